/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the loss gradient unit.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lgu_pkg.sv */
// Package of the loss gradient unit: widths, mode and register codes,
// and the command/status types of the shared arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package lgu_pkg;

  localparam int DATA_W        = 32;
  localparam int MODE_W        = 3;
  localparam int ROWS_W        = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int ACC_W         = 64;
  localparam int WIDE_W        = 128;
  localparam int DEF_MAX_ELEMS = 64;
  localparam int DEF_FRAC_BITS = 16;

  // loss_mode codes
  localparam logic [MODE_W-1:0] MODE_MSE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HINGE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NLL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COS   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd1;

  localparam logic [DATA_W-1:0] GRAD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] GRAD_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic [WIDE_W-1:0] opa;
    logic [WIDE_W-1:0] opb;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

endpackage

/* rtl/lgu_in_if.sv */
// Input request channel of the loss gradient unit: one prediction/target pair.
// Depends on lgu_pkg.
`timescale 1ns / 1ps

interface lgu_in_if;
  import lgu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] prediction;
  logic signed [DATA_W-1:0] target;
  logic                     last_pair;

  modport source (output valid, prediction, target, last_pair, input ready);
  modport sink   (input valid, prediction, target, last_pair, output ready);
endinterface

/* rtl/lgu_out_if.sv */
// Result request channel of the loss gradient unit: one gradient per element.
// Depends on lgu_pkg.
`timescale 1ns / 1ps

interface lgu_out_if;
  import lgu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] gradient;
  logic                     last_gradient;
  logic                     math_error;

  modport source (output valid, gradient, last_gradient, math_error, input ready);
  modport sink   (input valid, gradient, last_gradient, math_error, output ready);
endinterface

/* rtl/lgu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lgu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/lgu_arith.sv */
// Shared iterative arithmetic unit: 64x64 multiply, 128/128 divide and
// 128-bit integer square root, one step per cycle over one 129-bit adder.
// Depends on lgu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgu_arith (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lgu_pkg::arith_cmd_t       cmd,
  output lgu_pkg::arith_stat_t      stat,
  output logic [lgu_pkg::WIDE_W-1:0] result
);
  import lgu_pkg::*;

  localparam int ROOT_W = WIDE_W / 2;
  localparam int CNT_W  = $clog2(WIDE_W + 1);
  localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(WIDE_W / 2);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(WIDE_W);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(WIDE_W / 2);

  arith_op_t          op_r, op_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WIDE_W-1:0]  acc_r, acc_nxt;   // product / remainder
  logic [WIDE_W-1:0]  src_r, src_nxt;   // multiplicand / divisor
  logic [WIDE_W-1:0]  shf_r, shf_nxt;   // multiplier / dividend->quotient / radicand
  logic [ROOT_W-1:0]  root_r, root_nxt;

  logic [WIDE_W-1:0]  rem_div, rem_sqrt, trial, add_x, add_y;
  logic               add_cin, ge;
  logic [WIDE_W:0]    sum;

  // operand select for the one adder
  always_comb begin
    rem_div  = {acc_r[WIDE_W-2:0], shf_r[WIDE_W-1]};
    rem_sqrt = {acc_r[WIDE_W-3:0], shf_r[WIDE_W-1 -: 2]};
    trial    = {{(WIDE_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    case (op_r)
      OP_MUL: begin
        add_x   = acc_r << 1;
        add_y   = shf_r[WIDE_W-1] ? src_r : '0;
        add_cin = 1'b0;
      end
      OP_DIV: begin
        add_x   = rem_div;
        add_y   = ~src_r;
        add_cin = 1'b1;
      end
      OP_SQRT: begin
        add_x   = rem_sqrt;
        add_y   = ~trial;
        add_cin = 1'b1;
      end
      default: begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
      end
    endcase
    sum = {1'b0, add_x} + {1'b0, add_y} + {{WIDE_W{1'b0}}, add_cin};
    ge  = sum[WIDE_W];
  end

  // step sequencing
  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    src_nxt  = src_r;
    shf_nxt  = shf_r;
    root_nxt = root_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      acc_nxt  = '0;
      root_nxt = '0;
      case (cmd.op)
        OP_MUL: begin
          src_nxt = cmd.opa;
          shf_nxt = {cmd.opb[ROOT_W-1:0], {ROOT_W{1'b0}}};
          cnt_nxt = MUL_STEPS;
        end
        OP_DIV: begin
          src_nxt = cmd.opb;
          shf_nxt = cmd.opa;
          cnt_nxt = DIV_STEPS;
        end
        OP_SQRT: begin
          src_nxt = '0;
          shf_nxt = cmd.opa;
          cnt_nxt = SQRT_STEPS;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          acc_nxt = sum[WIDE_W-1:0];
          shf_nxt = shf_r << 1;
        end
        OP_DIV: begin
          acc_nxt = ge ? sum[WIDE_W-1:0] : rem_div;
          shf_nxt = {shf_r[WIDE_W-2:0], ge};
        end
        OP_SQRT: begin
          acc_nxt  = ge ? sum[WIDE_W-1:0] : rem_sqrt;
          shf_nxt  = shf_r << 2;
          root_nxt = {root_r[ROOT_W-2:0], ge};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    src_r  <= src_nxt;
    shf_r  <= shf_nxt;
    root_r <= root_nxt;
  end

  // result view per operation
  always_comb begin
    case (op_r)
      OP_MUL:  result = acc_r;
      OP_DIV:  result = shf_r;
      OP_SQRT: result = {{(WIDE_W-ROOT_W){1'b0}}, root_r};
      default: result = '0;
    endcase
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `ASSERT_IMPL(a_no_restart, cmd.start, !busy_r, "arith start while busy")
  `ASSERT_IMPL(a_done_follows_run, done_r, $past(busy_r), "arith done without a run")
  `ASSERT_IMPL(a_busy_has_steps, busy_r, cnt_r != '0, "arith busy with no steps left")

endmodule

/* rtl/loss_gradient_unit_core.sv */
// Loss gradient unit. Pairs are loaded one request at a time (accept, then p*t, p*p and
// t*t through one 32x32 multiplier and the running-sum update). The pair with last_pair
// set starts emission of one gradient per stored pair, in load order. MSE, MAE, NLL and
// cosine run on one shared iterative unit (one bit per cycle over a 129-bit adder):
// MSE, MAE and NLL use its 128-step divide, cosine two 64-step multiplies and the divide,
// plus a once-per-vector norm setup (multiply, 64-step square root, multiply); hinge
// tests the product of the load multiplier. Input is not ready during emission.
// Depends on lgu_pkg, lgu_in_if, lgu_out_if, lgu_ram, lgu_arith.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module loss_gradient_unit_core #(
  parameter int MAX_ELEMS = lgu_pkg::DEF_MAX_ELEMS,
  parameter int FRAC_BITS = lgu_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lgu_in_if.sink                          in_if,
  lgu_out_if.source                       out_if,
  input  logic                            cfg_wr_en,
  input  logic [lgu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lgu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lgu_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ELEMS);
  localparam logic [CNT_W-1:0]        MAX_CNT   = CNT_W'(MAX_ELEMS);
  localparam logic [WIDE_W-1:0]       ONE_F     = WIDE_W'(1) << FRAC_BITS;
  localparam logic [WIDE_W-1:0]       ONE_2F    = WIDE_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] HINGE_ONE = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic [ACC_W-1:0]        SQ_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]        DOT_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]        DOT_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_MPT   = 18'h00002,
    S_MPP   = 18'h00004,
    S_MTT   = 18'h00008,
    S_MEND  = 18'h00010,
    S_START = 18'h00020,
    S_NRM1  = 18'h00040,
    S_NRM2  = 18'h00080,
    S_NRM3  = 18'h00100,
    S_RD    = 18'h00200,
    S_EVAL  = 18'h00400,
    S_HMUL  = 18'h00800,
    S_HCHK  = 18'h01000,
    S_CM1   = 18'h02000,
    S_CM2   = 18'h04000,
    S_CABS  = 18'h08000,
    S_DIV   = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [ACC_W-1:0]    dot_r, dot_nxt;
  logic [ACC_W-1:0]    psum_r, psum_nxt;
  logic [ACC_W-1:0]    tsum_r, tsum_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [ROWS_W-1:0]   rows_r, rows_nxt;
  logic                last_r, last_nxt;

  logic [DATA_W-1:0]   p_r, p_nxt;
  logic [DATA_W-1:0]   t_r, t_nxt;
  logic signed [ACC_W-1:0] prod_r;
  logic [WIDE_W-1:0]   den_r, den_nxt;
  logic [WIDE_W-1:0]   m1_r, m1_nxt;
  logic [WIDE_W-1:0]   num_r, num_nxt;
  logic                neg_r, neg_nxt;
  logic [DATA_W-1:0]   grad_r, grad_nxt;
  logic                err_r, err_nxt;

  logic                in_acc, out_acc, ram_we, is_last;
  logic [DATA_W-1:0]   rd_pred, rd_targ;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0]  prod_full;
  logic [ACC_W-1:0]    sh;
  logic [ACC_W:0]      dsum;
  logic [ACC_W-1:0]    psum_add, tsum_add;

  logic [DATA_W:0]     diff;
  logic [DATA_W+1:0]   diff2, diff2_mag;
  logic [DATA_W-1:0]   pmag, tmag;
  logic [ACC_W-1:0]    dmag;
  logic [WIDE_W-1:0]   num_abs, q;
  logic                q_over_pos, q_over_neg;

  arith_cmd_t          acmd;
  arith_stat_t         astat;
  logic [WIDE_W-1:0]   ares;

  // pair stores
  lgu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_pred_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_if.prediction),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_pred)
  );

  lgu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_targ_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_if.target),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_targ)
  );

  lgu_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (acmd),
    .stat   (astat),
    .result (ares)
  );

  // handshakes
  assign in_if.ready  = (state_r == S_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_if.valid = (state_r == S_OUT);
  assign out_acc      = out_if.valid && out_if.ready;
  assign ram_we       = in_acc && (cnt_r < MAX_CNT);
  assign is_last      = ((idx_r + 1'b1) == cnt_r);

  assign out_if.gradient      = grad_r;
  assign out_if.last_gradient = is_last;
  assign out_if.math_error    = err_r;

  // load-side multiplier and running sums
  always_comb begin
    mul_a     = (state_r == S_MTT) ? $signed(t_r) : $signed(p_r);
    mul_b     = (state_r == S_MPP) ? $signed(p_r) : $signed(t_r);
    prod_full = mul_a * mul_b;
    sh        = prod_r >>> FRAC_BITS;
    dsum      = {dot_r[ACC_W-1], dot_r} + {sh[ACC_W-1], sh};
    psum_add  = psum_r + sh;
    tsum_add  = tsum_r + sh;
  end

  // per-element operands from the stores
  always_comb begin
    diff      = {rd_pred[DATA_W-1], rd_pred} - {rd_targ[DATA_W-1], rd_targ};
    diff2     = {diff, 1'b0};
    diff2_mag = diff[DATA_W] ? (~diff2 + 1'b1) : diff2;
    pmag      = rd_pred[DATA_W-1] ? (~rd_pred + 1'b1) : rd_pred;
    tmag      = t_r[DATA_W-1] ? (~t_r + 1'b1) : t_r;
    dmag      = dot_r[ACC_W-1] ? (~dot_r + 1'b1) : dot_r;
    num_abs   = num_r[WIDE_W-1] ? (~num_r + 1'b1) : num_r;
    q         = ares;
    q_over_pos = |q[WIDE_W-1:DATA_W-1];
    q_over_neg = (|q[WIDE_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    dot_nxt   = dot_r;
    psum_nxt  = psum_r;
    tsum_nxt  = tsum_r;
    mode_nxt  = mode_r;
    rows_nxt  = rows_r;
    last_nxt  = last_r;
    p_nxt     = p_r;
    t_nxt     = t_r;
    den_nxt   = den_r;
    m1_nxt    = m1_r;
    num_nxt   = num_r;
    neg_nxt   = neg_r;
    grad_nxt  = grad_r;
    err_nxt   = err_r;
    acmd      = '{start: 1'b0, op: OP_MUL, opa: '0, opb: '0};

    // register writes
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_MODE: mode_nxt = cfg_wdata[MODE_W-1:0];
        CFG_IDX_ROWS: rows_nxt = cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          p_nxt    = in_if.prediction;
          t_nxt    = in_if.target;
          last_nxt = in_if.last_pair;
          if (ram_we) begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_MPT;
          end else if (in_if.last_pair) begin
            state_nxt = S_START;
          end
        end
      end
      S_MPT: state_nxt = S_MPP;
      S_MPP: begin
        if (dsum[ACC_W] != dsum[ACC_W-1]) begin
          dot_nxt = dsum[ACC_W] ? DOT_MIN : DOT_MAX;
        end else begin
          dot_nxt = dsum[ACC_W-1:0];
        end
        state_nxt = S_MTT;
      end
      S_MTT: begin
        psum_nxt  = psum_add[ACC_W-1] ? SQ_MAX : psum_add;
        state_nxt = S_MEND;
      end
      S_MEND: begin
        tsum_nxt  = tsum_add[ACC_W-1] ? SQ_MAX : tsum_add;
        state_nxt = last_r ? S_START : S_IDLE;
      end
      S_START: begin
        idx_nxt = '0;
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end else if (mode_r == MODE_COS && psum_r != '0 && tsum_r != '0) begin
          acmd      = '{start: 1'b1, op: OP_MUL, opa: WIDE_W'(psum_r), opb: WIDE_W'(tsum_r)};
          state_nxt = S_NRM1;
        end else begin
          state_nxt = S_RD;
        end
      end
      // norm product, its root, then the cosine denominator
      S_NRM1: begin
        if (astat.done) begin
          acmd      = '{start: 1'b1, op: OP_SQRT, opa: ares, opb: '0};
          state_nxt = S_NRM2;
        end
      end
      S_NRM2: begin
        if (astat.done) begin
          acmd      = '{start: 1'b1, op: OP_MUL, opa: WIDE_W'(psum_r),
                        opb: WIDE_W'(ares[ACC_W-1:0])};
          state_nxt = S_NRM3;
        end
      end
      S_NRM3: begin
        if (astat.done) begin
          den_nxt   = ares;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        p_nxt   = rd_pred;
        t_nxt   = rd_targ;
        err_nxt = 1'b0;
        case (mode_r)
          MODE_MSE, MODE_MAE: begin
            if (rows_r == '0) begin
              err_nxt   = 1'b1;
              grad_nxt  = diff[DATA_W] ? GRAD_MIN : ((diff != '0) ? GRAD_MAX : '0);
              state_nxt = S_OUT;
            end else begin
              acmd.start = 1'b1;
              acmd.op    = OP_DIV;
              acmd.opb   = WIDE_W'(rows_r);
              if (mode_r == MODE_MSE) begin
                acmd.opa = WIDE_W'(diff2_mag);
              end else begin
                acmd.opa = (diff == '0) ? '0 : ONE_F;
              end
              neg_nxt   = diff[DATA_W];
              state_nxt = S_DIV;
            end
          end
          MODE_HINGE: state_nxt = S_HMUL;
          MODE_NLL: begin
            if (rd_pred == '0) begin
              err_nxt   = 1'b1;
              grad_nxt  = GRAD_MIN;
              state_nxt = S_OUT;
            end else begin
              acmd      = '{start: 1'b1, op: OP_DIV, opa: ONE_2F, opb: WIDE_W'(pmag)};
              neg_nxt   = !rd_pred[DATA_W-1];
              state_nxt = S_DIV;
            end
          end
          MODE_COS: begin
            if (psum_r == '0 || tsum_r == '0) begin
              err_nxt   = 1'b1;
              grad_nxt  = '0;
              state_nxt = S_OUT;
            end else begin
              acmd      = '{start: 1'b1, op: OP_MUL, opa: WIDE_W'(dmag),
                            opb: WIDE_W'(pmag)};
              neg_nxt   = dot_r[ACC_W-1] ^ rd_pred[DATA_W-1];
              state_nxt = S_CM1;
            end
          end
          default: begin
            err_nxt   = 1'b1;
            grad_nxt  = '0;
            state_nxt = S_OUT;
          end
        endcase
      end
      // hinge margin test on the exact product
      S_HMUL: state_nxt = S_HCHK;
      S_HCHK: begin
        if (prod_r < HINGE_ONE) begin
          if (t_r == GRAD_MIN) begin
            grad_nxt = GRAD_MAX;
            err_nxt  = 1'b1;
          end else begin
            grad_nxt = ~t_r + 1'b1;
          end
        end else begin
          grad_nxt = '0;
        end
        state_nxt = S_OUT;
      end
      // cosine numerator: D*p - t*P, signed
      S_CM1: begin
        if (astat.done) begin
          m1_nxt    = neg_r ? (~ares + 1'b1) : ares;
          acmd      = '{start: 1'b1, op: OP_MUL, opa: WIDE_W'(psum_r),
                        opb: WIDE_W'(tmag)};
          state_nxt = S_CM2;
        end
      end
      S_CM2: begin
        if (astat.done) begin
          num_nxt   = t_r[DATA_W-1] ? (m1_r + ares) : (m1_r - ares);
          state_nxt = S_CABS;
        end
      end
      S_CABS: begin
        neg_nxt   = num_r[WIDE_W-1];
        acmd      = '{start: 1'b1, op: OP_DIV, opa: num_abs << FRAC_BITS, opb: den_r};
        state_nxt = S_DIV;
      end
      // signed, saturated quotient
      S_DIV: begin
        if (astat.done) begin
          if (!neg_r) begin
            grad_nxt = q_over_pos ? GRAD_MAX : q[DATA_W-1:0];
            err_nxt  = q_over_pos;
          end else begin
            grad_nxt = q_over_neg ? GRAD_MIN : (~q[DATA_W-1:0] + 1'b1);
            err_nxt  = q_over_neg;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 1'b1;
          if (is_last) begin
            cnt_nxt   = '0;
            dot_nxt   = '0;
            psum_nxt  = '0;
            tsum_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      dot_r   <= '0;
      psum_r  <= '0;
      tsum_r  <= '0;
      mode_r  <= MODE_MSE;
      rows_r  <= ROWS_W'(1);
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      dot_r   <= dot_nxt;
      psum_r  <= psum_nxt;
      tsum_r  <= tsum_nxt;
      mode_r  <= mode_nxt;
      rows_r  <= rows_nxt;
      last_r  <= last_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    t_r    <= t_nxt;
    prod_r <= prod_full;
    den_r  <= den_nxt;
    m1_r   <= m1_nxt;
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
    grad_r <= grad_nxt;
    err_r  <= err_nxt;
  end

  `ASSERT_IMPL(a_out_has_elem, out_if.valid, (cnt_r != '0) && (idx_r < cnt_r), "no element")
  `ASSERT_NEXT(a_load_count, ram_we, cnt_r == $past(cnt_r) + 1'b1, "stored pair not counted")
  `ASSERT_NEXT(a_clear, out_acc && is_last, (cnt_r == '0) && (psum_r == '0), "not cleared")

endmodule

/* sim/lgu_grad_checker.sv */
// Checker of the loss gradient unit: watches the pair, gradient and register ports,
// predicts every gradient and compares it field by field. Depends on lgu_pkg and the
// lgu_in_if / lgu_out_if interfaces.
`timescale 1ns / 1ps

module lgu_grad_checker
  import lgu_pkg::*;
#(
  parameter int MAX_ELEMS = DEF_MAX_ELEMS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lgu_in_if                     in_ch,
  lgu_out_if                    out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic signed [DATA_W-1:0] grad;
    logic                     last;
    logic                     err;
  } grad_exp_t;

  grad_exp_t grad_q[$];

  logic signed [DATA_W-1:0] pred_mem[MAX_ELEMS];
  logic signed [DATA_W-1:0] tgt_mem[MAX_ELEMS];
  int                       elem_cnt;
  logic signed [63:0]       dot_sum;
  logic [63:0]              psq_sum;
  logic [63:0]              tsq_sum;
  logic [MODE_W-1:0]        mode_r;
  logic [ROWS_W-1:0]        rows_r;

  assign pending = grad_q.size();

  function automatic logic signed [31:0] clamp32(longint v, inout logic err);
    if (v > 64'sh7FFF_FFFF) begin
      err = 1'b1;
      return GRAD_MAX;
    end
    if (v < -64'sh8000_0000) begin
      err = 1'b1;
      return GRAD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] root128(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (x >= {64'd0, c} * {64'd0, c}) r = c;
    end
    return r;
  endfunction

  // cosine: (D*p - t*P) * 2^F / (P * floor(sqrt(P*T)))
  function automatic logic signed [31:0] cosine_grad(longint p, longint t, inout logic err);
    logic signed [127:0] dw, pw, tw, bigp, num;
    logic [127:0]        mag, den, q;
    logic [63:0]         root;
    logic                neg;
    if (psq_sum == 0 || tsq_sum == 0) begin
      err = 1'b1;
      return '0;
    end
    root = root128({64'd0, psq_sum} * {64'd0, tsq_sum});
    dw   = dot_sum;
    pw   = p;
    tw   = t;
    bigp = $signed({64'd0, psq_sum});
    num  = dw * pw - tw * bigp;
    neg  = num[127];
    mag  = neg ? -num : num;
    mag  = mag << FRAC_BITS;
    den  = {64'd0, psq_sum} * {64'd0, root};
    q    = mag / den;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        err = 1'b1;
        return GRAD_MAX;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      err = 1'b1;
      return GRAD_MIN;
    end
    return -q[31:0];
  endfunction

  function automatic logic signed [31:0] elem_grad(longint p, longint t, inout logic err);
    longint diff, sgn;
    diff = p - t;
    sgn  = diff > 0 ? 1 : (diff < 0 ? -1 : 0);
    case (mode_r)
      MODE_MSE, MODE_MAE: begin
        if (rows_r == 0) begin
          err = 1'b1;
          return sgn > 0 ? GRAD_MAX : (sgn < 0 ? GRAD_MIN : '0);
        end
        if (mode_r == MODE_MSE) return clamp32((2 * diff) / longint'(rows_r), err);
        return clamp32((sgn * (64'sd1 <<< FRAC_BITS)) / longint'(rows_r), err);
      end
      MODE_HINGE: begin
        if (t * p < (64'sd1 <<< (2 * FRAC_BITS))) return clamp32(-t, err);
        return '0;
      end
      MODE_NLL: begin
        if (p == 0) begin
          err = 1'b1;
          return GRAD_MIN;
        end
        return clamp32(-(64'sd1 <<< (2 * FRAC_BITS)) / p, err);
      end
      MODE_COS: return cosine_grad(p, t, err);
      default: begin
        err = 1'b1;
        return '0;
      end
    endcase
  endfunction

  // load one pair into the store and the running sums
  task automatic load_pair(logic signed [31:0] p, logic signed [31:0] t);
    logic signed [63:0] d;
    logic signed [64:0] acc;
    logic [64:0]        us;
    if (elem_cnt >= MAX_ELEMS) return;
    pred_mem[elem_cnt] = p;
    tgt_mem[elem_cnt]  = t;
    elem_cnt++;
    d   = (longint'(p) * longint'(t)) >>> FRAC_BITS;
    acc = $signed({dot_sum[63], dot_sum}) + $signed({d[63], d});
    if (acc > 65'sh0_7FFF_FFFF_FFFF_FFFF) dot_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (acc < -65'sh0_8000_0000_0000_0000) dot_sum = 64'sh8000_0000_0000_0000;
    else dot_sum = acc[63:0];
    d  = (longint'(p) * longint'(p)) >>> FRAC_BITS;
    us = {1'b0, psq_sum} + {1'b0, d};
    psq_sum = (us > 65'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : us[63:0];
    d  = (longint'(t) * longint'(t)) >>> FRAC_BITS;
    us = {1'b0, tsq_sum} + {1'b0, d};
    tsq_sum = (us > 65'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : us[63:0];
  endtask

  always @(posedge clk) begin
    grad_exp_t e;
    grad_exp_t got;
    if (!rst_n) begin
      grad_q.delete();
      elem_cnt = 0;
      dot_sum  = '0;
      psq_sum  = '0;
      tsq_sum  = '0;
      mode_r   = MODE_MSE;
      rows_r   = ROWS_W'(1);
      errors   = 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        if (cfg_index == CFG_IDX_MODE) mode_r = cfg_wdata[MODE_W-1:0];
        else if (cfg_index == CFG_IDX_ROWS) rows_r = cfg_wdata[ROWS_W-1:0];
      end
      // accepted pair; the marked one releases the whole vector
      if (in_ch.valid && in_ch.ready) begin
        load_pair(in_ch.prediction, in_ch.target);
        if (in_ch.last_pair) begin
          for (int i = 0; i < elem_cnt; i++) begin
            e.err  = 1'b0;
            e.grad = elem_grad(pred_mem[i], tgt_mem[i], e.err);
            e.last = (i + 1 == elem_cnt);
            grad_q.push_back(e);
          end
          elem_cnt = 0;
          dot_sum  = '0;
          psq_sum  = '0;
          tsq_sum  = '0;
        end
      end
      // accepted gradient against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        got.grad = out_ch.gradient;
        got.last = out_ch.last_gradient;
        got.err  = out_ch.math_error;
        if (grad_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected gradient %h last %b err %b", $time,
                   got.grad, got.last, got.err);
        end else begin
          e = grad_q.pop_front();
          if (got.grad !== e.grad) begin
            errors++;
            $display("%0t: gradient expected %h actual %h", $time, e.grad, got.grad);
          end
          if (got.last !== e.last) begin
            errors++;
            $display("%0t: last_gradient expected %b actual %b", $time, e.last, got.last);
          end
          if (got.err !== e.err) begin
            errors++;
            $display("%0t: math_error expected %b actual %b", $time, e.err, got.err);
          end
        end
      end
    end
  end

endmodule

/* sim/tb_loss_gradient_unit_core.sv */
// Testbench top of the loss gradient unit: clock, reset, pair requests, register
// writes and gradient back-pressure; the verdict comes from lgu_grad_checker.
// Depends on lgu_pkg, lgu_in_if, lgu_out_if, loss_gradient_unit_core, lgu_grad_checker.
`timescale 1ns / 1ps

module tb_loss_gradient_unit_core;
  import lgu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_BAD5 = MODE_COS + 3'd1;
  localparam logic [MODE_W-1:0] MODE_BAD6 = MODE_COS + 3'd2;
  localparam logic [MODE_W-1:0] MODE_BAD7 = MODE_COS + 3'd3;
  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] QONE = 32'sh0001_0000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  calm = 1'b0;
  logic                  hold_req = 1'b0;
  int                    errors;
  int                    pending;

  lgu_in_if  in_ch ();
  lgu_out_if out_ch ();

  loss_gradient_unit_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lgu_grad_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // gradient side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (700) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
      2: begin
        case ($urandom_range(0, 6))
          0: return QMAX;
          1: return QMIN;
          2: return QONE;
          3: return -QONE;
          4: return 32'sd1;
          5: return -32'sd1;
          default: return '0;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h1_FFFF)) - 32'sh1_0000;
    endcase
  endfunction

  task automatic send_pair(logic signed [31:0] p, logic signed [31:0] t, logic last);
    in_ch.valid      <= 1'b1;
    in_ch.prediction <= p;
    in_ch.target     <= t;
    in_ch.last_pair  <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_vector(int n);
    for (int i = 0; i < n; i++) send_pair(pick_value(), pick_value(), i == n - 1);
  endtask

  // wait until every gradient is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic [MODE_W-1:0] mode, logic [ROWS_W-1:0] rows);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_IDX_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [MODE_W-1:0] modes[14];
    logic [ROWS_W-1:0] rows[14];
    int                sent;
    in_ch.valid      = 1'b0;
    in_ch.prediction = '0;
    in_ch.target     = '0;
    in_ch.last_pair  = 1'b0;
    modes = '{MODE_MSE, MODE_MSE, MODE_MAE, MODE_HINGE, MODE_NLL, MODE_COS, MODE_MSE,
              MODE_MAE, MODE_BAD5, MODE_COS, MODE_MAE, MODE_HINGE, MODE_NLL, MODE_MSE};
    rows  = '{7'd64, 7'd0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd127,
              7'd0, 7'd1, 7'd3, 7'd64, 7'd5, 7'd1, 7'd3};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes under reset settings, then every mode
    send_pair(QMAX, QMIN, 1'b0);
    send_pair(QMIN, QMAX, 1'b0);
    send_pair('0, '0, 1'b1);
    drain();
    foreach (modes[k]) begin
      if (k > 5) break;
      set_regs(modes[k], rows[k]);
      send_pair(QMAX, QMIN, 1'b0);
      send_pair('0, QMIN, 1'b0);
      send_pair(QONE, -QONE, 1'b1);
      drain();
    end
    // zero norm in cosine, unknown codes
    set_regs(MODE_COS, 7'd1);
    send_pair('0, QONE, 1'b1);
    drain();
    set_regs(MODE_BAD6, 7'd1);
    send_pair(QONE, '0, 1'b1);
    drain();
    set_regs(MODE_BAD7, 7'd1);
    send_pair(-QONE, QONE, 1'b1);
    drain();

    // random vectors over a sweep of settings
    foreach (modes[k]) begin
      set_regs(modes[k], rows[k]);
      calm = (k >= 12);
      if (k == 2) send_vector(66);
      if (k == 4) hold_req = 1'b1;
      sent = 0;
      while (sent < 17) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        send_vector(n);
        sent += n;
      end
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* loss_gradient_unit_core.f */
+incdir+rtl
rtl/lgu_pkg.sv
rtl/lgu_in_if.sv
rtl/lgu_out_if.sv
rtl/lgu_ram.sv
rtl/lgu_arith.sv
rtl/loss_gradient_unit_core.sv
sim/lgu_grad_checker.sv
sim/tb_loss_gradient_unit_core.sv
